FILE: rtl/core/fmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmt_pkg: shared types and constants of the message tokenizer
// Parser modes, result kinds, delimiter kinds, error codes and the syntax
// characters of the message format.
// ----------------------------------------------------------------------------
package fmt_pkg;

	typedef enum logic [2:0] {
		MODE_SEG   = 3'd0,
		MODE_ELEM  = 3'd1,
		MODE_TEXT  = 3'd2,
		MODE_ESC   = 3'd3,
		MODE_BHDR  = 3'd4,
		MODE_BDATA = 3'd5,
		MODE_AFTER = 3'd6
	} mode_t;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_TEXT     = 2'd1;
	localparam logic [1:0] KIND_BINARY   = 2'd2;
	localparam logic [1:0] KIND_ELEM_END = 2'd3;

	localparam logic [1:0] DELIM_COLON = 2'd0;
	localparam logic [1:0] DELIM_PLUS  = 2'd1;
	localparam logic [1:0] DELIM_APOS  = 2'd2;

	localparam logic [2:0] ERR_OK          = 3'd0;
	localparam logic [2:0] ERR_NO_DELIM    = 3'd1;
	localparam logic [2:0] ERR_ESC_END     = 3'd2;
	localparam logic [2:0] ERR_BAD_BHDR    = 3'd3;
	localparam logic [2:0] ERR_BIN_TRUNC   = 3'd4;
	localparam logic [2:0] ERR_BIN_NODELIM = 3'd5;
	localparam logic [2:0] ERR_BIN_LONG    = 3'd6;
	localparam logic [2:0] ERR_COUNT_OVF   = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int LIMIT_W    = 16;
	localparam int CONSUMED_W = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

	typedef struct packed {
		logic [1:0]            kind;
		logic [7:0]            data_byte;
		logic [1:0]            delim_kind;
		logic                  done;
		logic [2:0]            error_code;
		logic [CONSUMED_W-1:0] consumed;
	} result_t;

endpackage

FILE: rtl/core/fmt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmt_step: next-state and result logic of the tokenizer
// Takes one byte and the current parser state and gives the result of that
// byte together with the state that follows it.
// ----------------------------------------------------------------------------
module fmt_step #(
	parameter int BIN_LEN_WIDTH = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic [7:0]                 in_byte,
	input  logic                       last_byte,
	input  fmt_pkg::mode_t             mode,
	input  logic [BIN_LEN_WIDTH-1:0]   bin_rem,
	input  logic [COUNT_WIDTH-1:0]     byte_cnt,
	input  logic [COUNT_WIDTH-1:0]     seg_base,
	input  logic                       finished,
	input  logic [fmt_pkg::LIMIT_W-1:0] bin_len_limit,
	output fmt_pkg::result_t           res,
	output fmt_pkg::mode_t             mode_nxt,
	output logic [BIN_LEN_WIDTH-1:0]   bin_rem_nxt,
	output logic [COUNT_WIDTH-1:0]     byte_cnt_nxt,
	output logic [COUNT_WIDTH-1:0]     seg_base_nxt,
	output logic                       finished_nxt
);
	import fmt_pkg::*;

	localparam int VW  = (BIN_LEN_WIDTH + 4 > LIMIT_W) ? BIN_LEN_WIDTH + 4 : LIMIT_W;
	localparam int CXW = (COUNT_WIDTH > CONSUMED_W) ? COUNT_WIDTH : CONSUMED_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [VW-1:0]    limit_v;
	logic [VW-1:0]    bin_max_v;
	logic [VW-1:0]    lim_v;
	logic [VW-1:0]    rem_v;
	logic [VW-1:0]    acc_v;
	logic [3:0]       digit;
	logic             is_digit;
	logic             is_delim;
	logic [1:0]       delim;
	logic [CXW-1:0]   cons_x;

	always_comb begin
		limit_v   = VW'(bin_len_limit);
		bin_max_v = VW'({BIN_LEN_WIDTH{1'b1}});
		lim_v     = (limit_v < bin_max_v) ? limit_v : bin_max_v;
		rem_v     = VW'(bin_rem);
		digit     = 4'(in_byte - CH_ZERO);
		is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		acc_v     = (rem_v << 3) + (rem_v << 1) + VW'(digit);
		is_delim  = (in_byte == CH_COLON) || (in_byte == CH_PLUS) || (in_byte == CH_APOS);
		delim     = (in_byte == CH_COLON) ? DELIM_COLON :
		            (in_byte == CH_PLUS)  ? DELIM_PLUS  : DELIM_APOS;
	end

	always_comb begin
		res          = '0;
		cons_x       = '0;
		mode_nxt     = mode;
		bin_rem_nxt  = bin_rem;
		byte_cnt_nxt = byte_cnt;
		seg_base_nxt = seg_base;
		finished_nxt = finished;

		if (finished) begin
			if (last_byte) begin
				finished_nxt = 1'b0;
				mode_nxt     = MODE_SEG;
				bin_rem_nxt  = '0;
				byte_cnt_nxt = '0;
				seg_base_nxt = '0;
			end
		end else begin
			if (mode == MODE_SEG && in_byte == CH_NUL) begin
				res.done = 1'b1;
			end else if (byte_cnt == CNT_MAX) begin
				res.done       = 1'b1;
				res.error_code = ERR_COUNT_OVF;
			end else begin
				byte_cnt_nxt = byte_cnt + COUNT_WIDTH'(1);
				case (mode)
					MODE_ESC: begin
						if (in_byte == CH_NUL) begin
							res.done       = 1'b1;
							res.error_code = ERR_ESC_END;
						end else begin
							res.kind      = KIND_TEXT;
							res.data_byte = in_byte;
							mode_nxt      = MODE_TEXT;
						end
					end
					MODE_BHDR: begin
						if (is_digit) begin
							if (acc_v > lim_v) begin
								res.done       = 1'b1;
								res.error_code = ERR_BIN_LONG;
							end else begin
								bin_rem_nxt = acc_v[BIN_LEN_WIDTH-1:0];
							end
						end else if (in_byte == CH_AT) begin
							mode_nxt = (bin_rem != '0) ? MODE_BDATA : MODE_AFTER;
						end else begin
							res.done       = 1'b1;
							res.error_code = ERR_BAD_BHDR;
						end
					end
					MODE_BDATA: begin
						res.kind      = KIND_BINARY;
						res.data_byte = in_byte;
						if (bin_rem != '0) begin
							bin_rem_nxt = bin_rem - BIN_LEN_WIDTH'(1);
						end
						if (bin_rem <= BIN_LEN_WIDTH'(1)) begin
							mode_nxt = MODE_AFTER;
						end
					end
					MODE_AFTER: begin
						if (is_delim) begin
							res.kind       = KIND_ELEM_END;
							res.delim_kind = delim;
							if (delim == DELIM_APOS) begin
								mode_nxt     = MODE_SEG;
								seg_base_nxt = byte_cnt + COUNT_WIDTH'(1);
							end else begin
								mode_nxt = MODE_ELEM;
							end
						end else begin
							res.done       = 1'b1;
							res.error_code = ERR_BIN_NODELIM;
						end
					end
					default: begin
						if (is_delim) begin
							res.kind       = KIND_ELEM_END;
							res.delim_kind = delim;
							if (delim == DELIM_APOS) begin
								mode_nxt     = MODE_SEG;
								seg_base_nxt = byte_cnt + COUNT_WIDTH'(1);
							end else begin
								mode_nxt = MODE_ELEM;
							end
						end else if (in_byte == CH_QUEST) begin
							mode_nxt = MODE_ESC;
						end else if (in_byte == CH_AT &&
						             (mode == MODE_SEG || mode == MODE_ELEM)) begin
							mode_nxt    = MODE_BHDR;
							bin_rem_nxt = '0;
						end else if (in_byte == CH_NUL) begin
							res.done       = 1'b1;
							res.error_code = ERR_NO_DELIM;
						end else begin
							res.kind      = KIND_TEXT;
							res.data_byte = in_byte;
							mode_nxt      = MODE_TEXT;
						end
					end
				endcase

				if (!res.done && last_byte) begin
					res.done = 1'b1;
					case (mode_nxt)
						MODE_SEG:   res.error_code = ERR_OK;
						MODE_ESC:   res.error_code = ERR_ESC_END;
						MODE_BHDR:  res.error_code = ERR_BAD_BHDR;
						MODE_BDATA: res.error_code = ERR_BIN_TRUNC;
						MODE_AFTER: res.error_code = ERR_BIN_NODELIM;
						default:    res.error_code = ERR_NO_DELIM;
					endcase
				end
			end

			if (res.done) begin
				if (res.error_code != ERR_OK) begin
					res.kind       = KIND_NONE;
					res.data_byte  = '0;
					res.delim_kind = DELIM_COLON;
					cons_x         = CXW'(seg_base_nxt);
				end else begin
					cons_x = CXW'(byte_cnt_nxt);
				end
				res.consumed = cons_x[CONSUMED_W-1:0];
				if (last_byte) begin
					finished_nxt = 1'b0;
					mode_nxt     = MODE_SEG;
					bin_rem_nxt  = '0;
					byte_cnt_nxt = '0;
					seg_base_nxt = '0;
				end else begin
					finished_nxt = 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/fints_message_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fints_message_tokenizer_unit: streaming tokenizer for banking messages
// Splits a message, one byte per item, into text bytes, binary bytes and
// element ends, and reports completion or the first error with a byte count.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | in_byte, last_byte
//  out      | out_valid / out_stall| kind, data_byte, delim_kind, done_res,
//           |                      | error_code, consumed
//  config   | cfg_we               | cfg_wdata (binary length limit)
//
//  One item per cycle while the result register is free; each item passes
//  through the input register and then the result register to the output.
//  The input register and the result register each hold one item, so input
//  is taken while a result waits, and stall on the output reaches the input
//  only once both are full. Reset returns the parser to a segment start and
//  the length limit to its maximum.
// ----------------------------------------------------------------------------
module fints_message_tokenizer_unit #(
	parameter int BIN_LEN_WIDTH = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fmt_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    data_byte,
	output logic [1:0]                    delim_kind,
	output logic                          done_res,
	output logic [2:0]                    error_code,
	output logic [fmt_pkg::CONSUMED_W-1:0] consumed
);
	import fmt_pkg::*;

	logic [LIMIT_W-1:0]       limit_q;
	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	mode_t                    mode_q;
	logic [BIN_LEN_WIDTH-1:0] bin_rem_q;
	logic [COUNT_WIDTH-1:0]   byte_cnt_q;
	logic [COUNT_WIDTH-1:0]   seg_base_q;
	logic                     finished_q;
	logic                     out_valid_q;
	result_t                  res_q;

	result_t                  res;
	mode_t                    mode_nxt;
	logic [BIN_LEN_WIDTH-1:0] bin_rem_nxt;
	logic [COUNT_WIDTH-1:0]   byte_cnt_nxt;
	logic [COUNT_WIDTH-1:0]   seg_base_nxt;
	logic                     finished_nxt;
	logic                     advance;
	logic                     in_take;
	logic                     step;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	fmt_step #(
		.BIN_LEN_WIDTH(BIN_LEN_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_step (
		.in_byte      (byte_s1),
		.last_byte    (last_s1),
		.mode         (mode_q),
		.bin_rem      (bin_rem_q),
		.byte_cnt     (byte_cnt_q),
		.seg_base     (seg_base_q),
		.finished     (finished_q),
		.bin_len_limit(limit_q),
		.res          (res),
		.mode_nxt     (mode_nxt),
		.bin_rem_nxt  (bin_rem_nxt),
		.byte_cnt_nxt (byte_cnt_nxt),
		.seg_base_nxt (seg_base_nxt),
		.finished_nxt (finished_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SEG;
			bin_rem_q   <= '0;
			byte_cnt_q  <= '0;
			seg_base_q  <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			mode_q      <= mode_nxt;
			bin_rem_q   <= bin_rem_nxt;
			byte_cnt_q  <= byte_cnt_nxt;
			seg_base_q  <= seg_base_nxt;
			finished_q  <= finished_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = res_q.kind;
	assign data_byte  = res_q.data_byte;
	assign delim_kind = res_q.delim_kind;
	assign done_res   = res_q.done;
	assign error_code = res_q.error_code;
	assign consumed   = res_q.consumed;

endmodule

FILE: rtl/core/fmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmt_checker: port-level checks of the message tokenizer
// Watches the result channel and checks how the result fields relate.
// ----------------------------------------------------------------------------
module fmt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     kind,
	input logic [7:0]                     data_byte,
	input logic [1:0]                     delim_kind,
	input logic                           done_res,
	input logic [2:0]                     error_code,
	input logic [fmt_pkg::CONSUMED_W-1:0] consumed
);
	import fmt_pkg::*;

	a_err_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> done_res)
		else $error("error code without done");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |->
			kind == KIND_NONE && data_byte == 8'h00 && delim_kind == DELIM_COLON)
		else $error("failing item carries data");

	a_delim_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ELEM_END |-> delim_kind == DELIM_COLON)
		else $error("delimiter kind outside an element end");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> consumed == '0 && error_code == ERR_OK)
		else $error("count or error code without done");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(delim_kind) && $stable(done_res) && $stable(error_code)
			&& $stable(consumed))
		else $error("stalled item changed");

endmodule

bind fints_message_tokenizer_unit fmt_checker u_fmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.data_byte (data_byte),
	.delim_kind(delim_kind),
	.done_res  (done_res),
	.error_code(error_code),
	.consumed  (consumed)
);

FILE: tb/sv/fints_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fints_tokenizer_checker: result predictor and scoreboard for the tokenizer
// Watches the configuration port and both item channels of the tokenizer. It
// keeps its own copy of the parser state, works out the result of every
// accepted input byte and compares each accepted result, field by field, with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module fints_tokenizer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fmt_pkg::LIMIT_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           last_byte,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [1:0]                     kind,
	input  logic [7:0]                     data_byte,
	input  logic [1:0]                     delim_kind,
	input  logic                           done_res,
	input  logic [2:0]                     error_code,
	input  logic [fmt_pkg::CONSUMED_W-1:0] consumed,
	output int                             fail_count,
	output int                             pending,
	output int                             results_seen,
	output int                             buffers_closed,
	output logic [7:0]                     codes_seen
);
	import fmt_pkg::*;

	localparam logic [CONSUMED_W-1:0] COUNT_MAX = '1;

	result_t                results_due[$];
	mode_t                  mode;
	logic [LIMIT_W-1:0]     bin_left;
	logic [CONSUMED_W-1:0]  byte_cnt;
	logic [CONSUMED_W-1:0]  seg_mark;
	logic [LIMIT_W-1:0]     len_limit;
	logic                   halted;

	function automatic void restart_parser();
		mode     = MODE_SEG;
		bin_left = '0;
		byte_cnt = '0;
		seg_mark = '0;
		halted   = 1'b0;
	endfunction

	function automatic result_t tokenize_byte(input logic [7:0] b, input logic fin);
		result_t     r;
		logic [1:0]  dk;
		logic        is_delim;
		int unsigned acc;
		r        = '0;
		is_delim = (b == CH_COLON) || (b == CH_PLUS) || (b == CH_APOS);
		dk       = (b == CH_COLON) ? DELIM_COLON : (b == CH_PLUS) ? DELIM_PLUS : DELIM_APOS;
		if (halted) begin
			if (fin)
				restart_parser();
		end else if (mode == MODE_SEG && b == CH_NUL) begin
			r.done = 1'b1;
		end else if (byte_cnt == COUNT_MAX) begin
			r.done       = 1'b1;
			r.error_code = ERR_COUNT_OVF;
		end else begin
			byte_cnt++;
			if (mode == MODE_ESC) begin
				if (b == CH_NUL) begin
					r.done       = 1'b1;
					r.error_code = ERR_ESC_END;
				end else begin
					r.kind      = KIND_TEXT;
					r.data_byte = b;
					mode        = MODE_TEXT;
				end
			end else if (mode == MODE_BHDR) begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					acc = 32'(bin_left) * 10 + 32'(b - CH_ZERO);
					if (acc > 32'(len_limit)) begin
						r.done       = 1'b1;
						r.error_code = ERR_BIN_LONG;
					end else begin
						bin_left = acc[LIMIT_W-1:0];
					end
				end else if (b == CH_AT) begin
					if (bin_left != 0)
						mode = MODE_BDATA;
					else
						mode = MODE_AFTER;
				end else begin
					r.done       = 1'b1;
					r.error_code = ERR_BAD_BHDR;
				end
			end else if (mode == MODE_BDATA) begin
				r.kind      = KIND_BINARY;
				r.data_byte = b;
				if (bin_left != 0)
					bin_left--;
				if (bin_left == 0)
					mode = MODE_AFTER;
			end else if (is_delim) begin
				r.kind       = KIND_ELEM_END;
				r.delim_kind = dk;
				if (dk == DELIM_APOS) begin
					mode     = MODE_SEG;
					seg_mark = byte_cnt;
				end else begin
					mode = MODE_ELEM;
				end
			end else if (mode == MODE_AFTER) begin
				r.done       = 1'b1;
				r.error_code = ERR_BIN_NODELIM;
			end else if (b == CH_QUEST) begin
				mode = MODE_ESC;
			end else if (b == CH_AT && (mode == MODE_SEG || mode == MODE_ELEM)) begin
				mode     = MODE_BHDR;
				bin_left = '0;
			end else if (b == CH_NUL) begin
				r.done       = 1'b1;
				r.error_code = ERR_NO_DELIM;
			end else begin
				r.kind      = KIND_TEXT;
				r.data_byte = b;
				mode        = MODE_TEXT;
			end
			if (!r.done && fin) begin
				r.done = 1'b1;
				case (mode)
					MODE_SEG:   r.error_code = ERR_OK;
					MODE_ESC:   r.error_code = ERR_ESC_END;
					MODE_BHDR:  r.error_code = ERR_BAD_BHDR;
					MODE_BDATA: r.error_code = ERR_BIN_TRUNC;
					MODE_AFTER: r.error_code = ERR_BIN_NODELIM;
					default:    r.error_code = ERR_NO_DELIM;
				endcase
			end
		end
		if (r.done) begin
			if (r.error_code != ERR_OK) begin
				r.kind       = KIND_NONE;
				r.data_byte  = '0;
				r.delim_kind = DELIM_COLON;
				r.consumed   = seg_mark;
			end else begin
				r.consumed = byte_cnt;
			end
			if (fin)
				restart_parser();
			else
				halted = 1'b1;
		end
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want_r;
		result_t got_r;
		if (!arst_n) begin
			restart_parser();
			len_limit = LIMIT_RESET;
			results_due.delete();
			fail_count     = 0;
			results_seen   = 0;
			buffers_closed = 0;
			codes_seen     = '0;
			pending <= 0;
		end else begin
			if (cfg_we)
				len_limit = cfg_wdata;
			if (out_valid && !out_stall) begin
				got_r = '{kind, data_byte, delim_kind, done_res, error_code, consumed};
				results_seen++;
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 30)
						$error("Result with no item outstanding: kind %0d, done %0d",
							kind, done_res);
				end else begin
					want_r = results_due.pop_front();
					check_field("kind", want_r.kind, got_r.kind);
					check_field("data_byte", want_r.data_byte, got_r.data_byte);
					check_field("delim_kind", want_r.delim_kind, got_r.delim_kind);
					check_field("done_res", want_r.done, got_r.done);
					check_field("error_code", want_r.error_code, got_r.error_code);
					check_field("consumed", want_r.consumed, got_r.consumed);
					if (want_r.done) begin
						buffers_closed++;
						codes_seen[want_r.error_code] = 1'b1;
					end
				end
			end
			if (in_valid && !in_stall)
				results_due.push_back(tokenize_byte(in_byte, last_byte));
			pending <= results_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_fints_message_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fints_message_tokenizer_unit: stimulus and verdict for the tokenizer
// Feeds message buffers byte by byte: a few hand-written buffers, then random
// segments with text, escapes and binary elements under several length limits,
// broken and noisy buffers among them. Both channels idle at random, except
// for one stretch of buffers sent with neither side idling.
// ----------------------------------------------------------------------------
module tb_fints_message_tokenizer_unit;
	import fmt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [LIMIT_W-1:0]    cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte = '0;
	logic                  last_byte = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            kind;
	logic [7:0]            data_byte;
	logic [1:0]            delim_kind;
	logic                  done_res;
	logic [2:0]            error_code;
	logic [CONSUMED_W-1:0] consumed;

	int         fail_count;
	int         pending;
	int         results_seen;
	int         buffers_closed;
	logic [7:0] codes_seen;

	int         idle_pct = 31;
	int         stall_pct = 31;
	int         items_sent = 0;
	int         cycle_count = 0;
	logic [7:0] msg[$];

	fints_message_tokenizer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.delim_kind (delim_kind),
		.done_res   (done_res),
		.error_code (error_code),
		.consumed   (consumed)
	);

	fints_tokenizer_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.delim_kind     (delim_kind),
		.done_res       (done_res),
		.error_code     (error_code),
		.consumed       (consumed),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.buffers_closed (buffers_closed),
		.codes_seen     (codes_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL fints_message_tokenizer_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		while (b == CH_APOS || b == CH_PLUS || b == CH_COLON || b == CH_QUEST || b == CH_AT)
			b = 8'($urandom_range(1, 255));
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_msg(input int stop);
		for (int i = 0; i <= stop; i++)
			send_byte(msg[i], i == stop);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic build_message();
		int    nseg;
		int    nelem;
		int    n;
		string digits;
		msg.delete();
		nseg = $urandom_range(1, 3);
		for (int s = 0; s < nseg; s++) begin
			nelem = $urandom_range(1, 4);
			for (int e = 0; e < nelem; e++) begin
				if ($urandom_range(3) == 0) begin
					n = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
					digits = $sformatf("%0d", n);
					if ($urandom_range(5) == 0)
						digits = {"0", digits};
					msg.push_back(CH_AT);
					for (int i = 0; i < digits.len(); i++)
						msg.push_back(digits[i]);
					msg.push_back(CH_AT);
					repeat (n) msg.push_back(8'($urandom_range(255)));
				end else begin
					repeat ($urandom_range(0, 5)) begin
						if ($urandom_range(5) == 0) begin
							msg.push_back(CH_QUEST);
							msg.push_back(8'($urandom_range(1, 255)));
						end else begin
							msg.push_back(text_byte());
						end
					end
				end
				if (e != nelem - 1)
					msg.push_back($urandom_range(1) ? CH_COLON : CH_PLUS);
			end
			msg.push_back(CH_APOS);
		end
	endtask

	task automatic send_random_message();
		int pick;
		int stop;
		build_message();
		pick = $urandom_range(9);
		stop = msg.size() - 1;
		if (pick >= 4 && pick <= 6) begin
			msg.push_back(CH_NUL);
			repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(255)));
			stop = msg.size() - 1;
		end else if (pick >= 7 && pick <= 8) begin
			stop = $urandom_range(stop);
		end else if (pick == 9) begin
			msg[$urandom_range(stop)] = 8'($urandom_range(255));
		end
		send_msg(stop);
	endtask

	initial begin
		logic [LIMIT_W-1:0] limits[4];
		int                 target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Text, escape, binary bytes 0x00 and 0xFF, every delimiter, NUL end
		// with a trailing ignored byte; then the length limit at its edge.
		msg = '{"a", CH_QUEST, CH_APOS, CH_PLUS, CH_AT, "2", CH_AT, 8'h00, 8'hFF,
			CH_COLON, CH_APOS, CH_NUL, "z"};
		send_msg(msg.size() - 1);
		msg = '{CH_AT, "6", "5", "5", "3", "6", "x"};
		send_msg(msg.size() - 1);
		msg = '{CH_AT, "6", "5", "5", "3", "5", CH_AT, "Q"};
		send_msg(msg.size() - 1);

		// The third limit is run with neither side idling.
		limits = '{16'd0, 16'd5, 16'($urandom_range(6, 60)), 16'hFFFF};
		target = items_sent;
		foreach (limits[p]) begin
			write_limit(limits[p]);
			idle_pct  = (p == 2) ? 0 : 31;
			stall_pct = (p == 2) ? 0 : 31;
			target += 170;
			while (items_sent < target)
				send_random_message();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Run covered %0d bytes in, %0d results checked, %0d buffers closed.",
			items_sent, results_seen, buffers_closed);
		$display("Error codes reached (one bit per code, ok in bit 0): %b", codes_seen);
		if (fail_count == 0)
			$display("PASS fints_message_tokenizer_unit");
		else
			$display("FAIL fints_message_tokenizer_unit");
		$finish;
	end

endmodule
